/* rtl/abk_pkg.sv */
// shared types and constants for the angle and gyro bias kalman filter
// no dependencies; used by every rtl file of the block
package abk_pkg;

  localparam int FRAC = 28;

  localparam logic [31:0] TIME_STEP_RST     = 32'd5368709;
  localparam logic [31:0] ANGLE_NOISE_RST   = 32'd268435;
  localparam logic [31:0] BIAS_NOISE_RST    = 32'd805306;
  localparam logic [31:0] MEASURE_NOISE_RST = 32'd8053064;

  typedef enum logic [1:0] {
    CFG_TIME_STEP     = 2'd0,
    CFG_ANGLE_NOISE   = 2'd1,
    CFG_BIAS_NOISE    = 2'd2,
    CFG_MEASURE_NOISE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] gyro_dps;
    logic signed [31:0] measured_angle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_RATE,
    ST_M_P3,
    ST_M_INNER,
    ST_M_BN,
    ST_D_K0,
    ST_D_K1,
    ST_M_ANG,
    ST_M_BIAS,
    ST_M_C2,
    ST_M_C3,
    ST_M_C0,
    ST_M_C1,
    ST_FIN
  } state_t;

endpackage

/* rtl/angle_bias_kalman_filter.sv */
// two-state kalman filter for one tilt axis (angle and gyro bias)
// depends on abk_pkg, abk_mul and abk_div
//
// one item at a time: in_ready is high only while the filter is idle. each
// item runs ten fixed point multiplies and two gain divisions in sequence on
// one shared multiplier and one restoring divider. the result sits in an
// output register; the next item is taken while it waits.
// angle and bias are kept at DATA_WIDTH bits with 16 fraction bits, the
// covariance at DATA_WIDTH bits with 28 fraction bits; every stored value
// saturates, and the outputs saturate to 32 bits. configuration registers
// are written through cfg_we/cfg_idx/cfg_wdata; the user must write them
// only while idle, as the block itself does not enforce it.
module angle_bias_kalman_filter #(
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  abk_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output abk_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_idx,
  input  logic [31:0]    cfg_wdata
);

  localparam int W  = DATA_WIDTH;
  // operand width: holds full width sums and the 32-bit registers as signed
  localparam int OW = ((W > 33) ? W : 33) + 3;
  localparam int SW = OW + 1;
  localparam logic signed [SW-1:0] TOPX = (SW'(1) <<< (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] BOTX = -TOPX - SW'(1);
  localparam logic signed [SW-1:0] TOP32 = (SW'(1) <<< 31) - SW'(1);
  localparam logic signed [SW-1:0] BOT32 = -TOP32 - SW'(1);

  function automatic logic signed [SW-1:0] sxw(input logic [W-1:0] v);
    return $signed({{(SW-W){v[W-1]}}, v});
  endfunction

  function automatic logic signed [SW-1:0] sxo(input logic [OW-1:0] v);
    return $signed({{(SW-OW){v[OW-1]}}, v});
  endfunction

  function automatic logic signed [SW-1:0] sx32(input logic [31:0] v);
    return $signed({{(SW-32){v[31]}}, v});
  endfunction

  function automatic logic signed [SW-1:0] zx32(input logic [31:0] v);
    return $signed({{(SW-32){1'b0}}, v});
  endfunction

  function automatic logic signed [W-1:0] satw(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > TOPX) ? TOPX : ((v < BOTX) ? BOTX : v);
    return c[W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > TOP32) ? TOP32 : ((v < BOT32) ? BOT32 : v);
    return c[31:0];
  endfunction

  // configuration registers
  logic [31:0] dt_r, an_r, bn_r, mn_r;

  // filter state
  logic signed [W-1:0] ang_r, bias_r, p0_r, p1_r, p2_r, p3_r;
  logic signed [W-1:0] ang_nxt, bias_nxt, p0_nxt, p1_nxt, p2_nxt, p3_nxt;

  // per item working registers
  logic signed [31:0]   gyro_r, meas_r;
  logic signed [W-1:0]  t_r, k0_r, k1_r;
  logic signed [W-1:0]  t_nxt, k0_nxt, k1_nxt;
  logic signed [SW-1:0] y_r, y_nxt;

  abk_pkg::state_t state_r, state_nxt;
  logic            issued_r, issued_nxt;
  logic            out_valid_r, out_valid_nxt;
  abk_pkg::out_t   out_r, out_nxt;

  // shared units
  logic                 mul_start, mul_done, div_start, div_done;
  logic signed [SW-1:0] opa, opb, dnum, dden;
  logic signed [OW-1:0] mul_res;
  logic signed [W-1:0]  div_res;
  logic signed [SW-1:0] m;
  logic                 in_xfer;

  assign in_xfer = in_valid && in_ready;
  assign m       = sxo(mul_res);

  abk_mul #(.W(W), .OW(OW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa[OW-1:0]),
    .b     (opb[OW-1:0]),
    .done  (mul_done),
    .res   (mul_res)
  );

  abk_div #(.W(W), .OW(OW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (dnum[W-1:0]),
    .d     (dden[OW-1:0]),
    .done  (div_done),
    .res   (div_res)
  );

  // sequencer: each step issues one operation, then applies its result
  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ang_nxt  = ang_r;
    bias_nxt = bias_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    p2_nxt   = p2_r;
    p3_nxt   = p3_r;
    t_nxt    = t_r;
    k0_nxt   = k0_r;
    k1_nxt   = k1_r;
    y_nxt    = y_r;
    opa  = '0;
    opb  = '0;
    dnum = sxw(p0_r);
    dden = sxw(p0_r) + zx32(mn_r);
    mul_start = 1'b0;
    div_start = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      abk_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = abk_pkg::ST_M_RATE;
        end
      end
      abk_pkg::ST_M_RATE: begin
        opa = zx32(dt_r);
        opb = sxw(satw(sx32(gyro_r) - sxw(bias_r)));
        if (mul_done) begin
          ang_nxt   = satw(sxw(ang_r) + m);
          state_nxt = abk_pkg::ST_M_P3;
        end
      end
      abk_pkg::ST_M_P3: begin
        opa = zx32(dt_r);
        opb = sxw(p3_r);
        if (mul_done) begin
          t_nxt     = satw(m);
          state_nxt = abk_pkg::ST_M_INNER;
        end
      end
      abk_pkg::ST_M_INNER: begin
        opa = zx32(dt_r);
        opb = sxw(t_r) - sxw(p1_r) - sxw(p2_r) + zx32(an_r);
        if (mul_done) begin
          p0_nxt    = satw(sxw(p0_r) + m);
          p1_nxt    = satw(sxw(p1_r) - sxw(t_r));
          p2_nxt    = satw(sxw(p2_r) - sxw(t_r));
          state_nxt = abk_pkg::ST_M_BN;
        end
      end
      abk_pkg::ST_M_BN: begin
        opa = zx32(bn_r);
        opb = zx32(dt_r);
        if (mul_done) begin
          p3_nxt    = satw(sxw(p3_r) + m);
          state_nxt = abk_pkg::ST_D_K0;
        end
      end
      abk_pkg::ST_D_K0: begin
        if (div_done) begin
          k0_nxt    = div_res;
          state_nxt = abk_pkg::ST_D_K1;
        end
      end
      abk_pkg::ST_D_K1: begin
        dnum = sxw(p2_r);
        if (div_done) begin
          k1_nxt    = div_res;
          y_nxt     = sx32(meas_r) - sxw(ang_r);
          state_nxt = abk_pkg::ST_M_ANG;
        end
      end
      abk_pkg::ST_M_ANG: begin
        opa = sxw(k0_r);
        opb = y_r;
        if (mul_done) begin
          ang_nxt   = satw(sxw(ang_r) + m);
          state_nxt = abk_pkg::ST_M_BIAS;
        end
      end
      abk_pkg::ST_M_BIAS: begin
        opa = sxw(k1_r);
        opb = y_r;
        if (mul_done) begin
          bias_nxt  = satw(sxw(bias_r) + m);
          state_nxt = abk_pkg::ST_M_C2;
        end
      end
      // off-diagonal and p11 first, so p00 and p01 are still the old values
      abk_pkg::ST_M_C2: begin
        opa = sxw(k1_r);
        opb = sxw(p0_r);
        if (mul_done) begin
          p2_nxt    = satw(sxw(p2_r) - m);
          state_nxt = abk_pkg::ST_M_C3;
        end
      end
      abk_pkg::ST_M_C3: begin
        opa = sxw(k1_r);
        opb = sxw(p1_r);
        if (mul_done) begin
          p3_nxt    = satw(sxw(p3_r) - m);
          state_nxt = abk_pkg::ST_M_C0;
        end
      end
      abk_pkg::ST_M_C0: begin
        opa = sxw(k0_r);
        opb = sxw(p0_r);
        if (mul_done) begin
          p0_nxt    = satw(sxw(p0_r) - m);
          state_nxt = abk_pkg::ST_M_C1;
        end
      end
      abk_pkg::ST_M_C1: begin
        opa = sxw(k0_r);
        opb = sxw(p1_r);
        if (mul_done) begin
          p1_nxt    = satw(sxw(p1_r) - m);
          state_nxt = abk_pkg::ST_FIN;
        end
      end
      abk_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_nxt.angle_estimate = sat32(sxw(ang_r));
          out_nxt.bias_estimate  = sat32(sxw(bias_r));
          out_valid_nxt          = 1'b1;
          state_nxt              = abk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = abk_pkg::ST_IDLE;
      end
    endcase

    // issue once on entry to an operation step, re-arm when it finishes
    if (state_r == abk_pkg::ST_D_K0 || state_r == abk_pkg::ST_D_K1) begin
      div_start = !issued_r;
      issued_nxt = div_done ? 1'b0 : 1'b1;
    end else if (state_r != abk_pkg::ST_IDLE && state_r != abk_pkg::ST_FIN) begin
      mul_start = !issued_r;
      issued_nxt = mul_done ? 1'b0 : 1'b1;
    end else begin
      issued_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abk_pkg::ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      dt_r   <= abk_pkg::TIME_STEP_RST;
      an_r   <= abk_pkg::ANGLE_NOISE_RST;
      bn_r   <= abk_pkg::BIAS_NOISE_RST;
      mn_r   <= abk_pkg::MEASURE_NOISE_RST;
      ang_r  <= '0;
      bias_r <= '0;
      p0_r   <= '0;
      p1_r   <= '0;
      p2_r   <= '0;
      p3_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r  <= ang_nxt;
      bias_r <= bias_nxt;
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      p3_r   <= p3_nxt;
      if (cfg_we) begin
        case (abk_pkg::cfg_idx_t'(cfg_idx))
          abk_pkg::CFG_TIME_STEP:     dt_r <= cfg_wdata;
          abk_pkg::CFG_ANGLE_NOISE:   an_r <= cfg_wdata;
          abk_pkg::CFG_BIAS_NOISE:    bn_r <= cfg_wdata;
          abk_pkg::CFG_MEASURE_NOISE: mn_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    k0_r  <= k0_nxt;
    k1_r  <= k1_nxt;
    y_r   <= y_nxt;
    out_r <= out_nxt;
    if (in_xfer) begin
      gyro_r <= in_data.gyro_dps;
      meas_r <= in_data.measured_angle;
    end
  end

  assign in_ready  = (state_r == abk_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/abk_mul.sv */
// shared fixed point multiplier: round(a*b / 2^28), ties away from zero
// one 16-bit digit of b per cycle; uses abk_pkg
module abk_mul #(
  parameter int W  = 32,
  parameter int OW = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [OW-1:0] a,
  input  logic signed [OW-1:0] b,
  output logic                 done,
  output logic signed [OW-1:0] res
);

  localparam int DG = 16;
  localparam int ND = (OW + DG - 1) / DG;
  localparam int BW = ND * DG;
  localparam int PW = OW + BW;
  localparam int MW = PW - abk_pkg::FRAC;
  localparam int CW = $clog2(ND + 1);
  localparam logic [MW-1:0] CAP = MW'(1) << W;

  logic [OW-1:0] am_r;
  logic [BW-1:0] bm_r;
  logic [PW-1:0] acc_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic signed [OW-1:0] res_r;

  logic [OW-1:0]    amag, bmag;
  logic [OW+DG-1:0] prod;
  logic [PW-1:0]    acc_nxt, rnd;
  logic [MW-1:0]    mag, capm;
  logic [OW-1:0]    capo;

  always_comb begin
    amag    = a[OW-1] ? OW'(-a) : OW'(a);
    bmag    = b[OW-1] ? OW'(-b) : OW'(b);
    prod    = am_r * bm_r[BW-1 -: DG];
    acc_nxt = (acc_r << DG) + PW'(prod);
    rnd     = acc_r + (PW'(1) << (abk_pkg::FRAC - 1));
    mag     = rnd[PW-1:abk_pkg::FRAC];
    capm    = (mag > CAP) ? CAP : mag;
    capo    = capm[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        am_r   <= amag;
        bm_r   <= BW'(bmag);
        acc_r  <= '0;
        neg_r  <= a[OW-1] ^ b[OW-1];
        cnt_r  <= CW'(ND);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          acc_r <= acc_nxt;
          bm_r  <= bm_r << DG;
          cnt_r <= cnt_r - CW'(1);
        end else begin
          res_r  <= neg_r ? -$signed(capo) : $signed(capo);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/abk_div.sv */
// restoring divider for the gains: round(n * 2^28 / d), saturated to W bits
// one quotient bit per cycle; uses abk_pkg
module abk_div #(
  parameter int W  = 32,
  parameter int OW = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [W-1:0]  n,
  input  logic signed [OW-1:0] d,
  output logic                 done,
  output logic signed [W-1:0]  res
);

  localparam int NB = W + abk_pkg::FRAC;
  localparam int CW = $clog2(NB + 1);
  localparam logic [NB:0] HALF = (NB+1)'(1) << (W - 1);

  logic [NB-1:0] num_r, q_r;
  logic [OW-1:0] ud_r, r_r;
  logic          neg_r, dz_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic signed [W-1:0] res_r;

  logic [W-1:0]  nmag;
  logic [OW-1:0] dmag;
  logic [OW:0]   rs, df;
  logic          ge, up;
  logic [NB:0]   qr;
  logic [W-1:0]  sat;

  always_comb begin
    nmag = n[W-1] ? W'(-n) : W'(n);
    dmag = d[OW-1] ? OW'(-d) : OW'(d);
    rs   = {r_r, num_r[NB-1]};
    ge   = rs >= {1'b0, ud_r};
    df   = rs - {1'b0, ud_r};
    up   = {r_r, 1'b0} >= {1'b0, ud_r};
    qr   = {1'b0, q_r} + (NB+1)'(up);
    if (dz_r) begin
      sat = '0;
    end else if (neg_r) begin
      sat = (qr > HALF) ? {1'b1, {(W-1){1'b0}}} : W'(-qr[W-1:0]);
    end else begin
      sat = (qr > HALF - (NB+1)'(1)) ? {1'b0, {(W-1){1'b1}}} : qr[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= {nmag, {abk_pkg::FRAC{1'b0}}};
        ud_r   <= dmag;
        r_r    <= '0;
        q_r    <= '0;
        neg_r  <= n[W-1] ^ d[OW-1];
        dz_r   <= (d == '0);
        cnt_r  <= CW'(NB);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          r_r   <= ge ? df[OW-1:0] : rs[OW-1:0];
          q_r   <= {q_r[NB-2:0], ge};
          num_r <= num_r << 1;
          cnt_r <= cnt_r - CW'(1);
        end else begin
          res_r  <= $signed(sat);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
